>>> rtl/core/dv16_pkg.sv
// ----------------------------------------------------------------------------
// dv16_pkg
// Shared types and constants for the 32 by 16 bit divide unit.
// ----------------------------------------------------------------------------
package dv16_pkg;

    localparam int unsigned DVD_W  = 32;
    localparam int unsigned DVS_W  = 16;
    localparam int unsigned FLAG_W = 4;

    // Stream word widths, padded to whole bytes.
    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned M_TDATA_W = 40;

    // Operation select.
    localparam logic OP_DIVU = 1'b0;
    localparam logic OP_DIVS = 1'b1;

    // Flag bit positions.
    localparam int unsigned FLAG_N = 3;
    localparam int unsigned FLAG_Z = 2;
    localparam int unsigned FLAG_V = 1;
    localparam int unsigned FLAG_C = 0;

    // Largest signed quotient magnitudes that still fit in 16 bits.
    localparam logic [DVD_W-1:0] QUO_POS_MAX = 32'd32767;
    localparam logic [DVD_W-1:0] QUO_NEG_MAX = 32'd32768;

    // One word in flight through the divider stages.
    typedef struct packed {
        logic              op;
        logic              neg_dvd;
        logic              neg_quo;
        logic              div_zero;
        logic [FLAG_W-1:0] flags;
        logic [DVD_W-1:0]  dvd;
        logic [DVD_W-1:0]  quo;
        logic [DVS_W-1:0]  rem;
        logic [DVS_W-1:0]  dvs_mag;
    } t_div_word;

endpackage

>>> rtl/core/dv16_step_stage.sv
// ----------------------------------------------------------------------------
// dv16_step_stage
// One pipeline stage of the restoring divider: retires BITS_PER_STAGE quotient bits
// per word and registers the word with its valid bit.
// ----------------------------------------------------------------------------
module dv16_step_stage #(
    parameter int unsigned BITS_PER_STAGE = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  dv16_pkg::t_div_word i_word,
    output logic                o_valid,
    output dv16_pkg::t_div_word o_word
);

    logic                r_valid;
    dv16_pkg::t_div_word r_word;
    dv16_pkg::t_div_word n_word;

    always_comb begin
        logic [dv16_pkg::DVS_W:0] sh;
        n_word = i_word;
        sh     = '0;
        for (int k = 0; k < BITS_PER_STAGE; k++) begin
            // Shift the next dividend bit into the partial remainder.
            sh          = {n_word.rem, n_word.quo[dv16_pkg::DVD_W-1]};
            n_word.quo  = {n_word.quo[dv16_pkg::DVD_W-2:0], 1'b0};
            if (sh >= {1'b0, n_word.dvs_mag}) begin
                sh            = sh - {1'b0, n_word.dvs_mag};
                n_word.quo[0] = 1'b1;
            end
            n_word.rem = sh[dv16_pkg::DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

>>> rtl/core/divide_32_by_16_unit.sv
// ----------------------------------------------------------------------------
// divide_32_by_16_unit
// Pipelined DIVU/DIVS: 32-bit dividend by 16-bit divisor with flag update.
// ----------------------------------------------------------------------------
// The unit accepts one word per clock while the output is not stalled, and
// each result passes from the operand conditioning register through the
// chain of restoring divide stages, each retiring BITS_PER_STAGE quotient
// bits (four by default), to the result register. A stall on the output
// freezes the whole pipeline, so words are never dropped or repeated, and a
// new word is taken whenever the result register is empty or is being read.
module divide_32_by_16_unit #(
    parameter int unsigned BITS_PER_STAGE = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // dividend[31:0], divisor[47:32], flags_in[51:48], zero pad[55:52]
    input  logic [dv16_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // op[0]
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // result[31:0], flags_out[35:32], zero pad[39:36]
    output logic [dv16_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // write_back[0], zero_divide[1]
    output logic [1:0]                       o_m_tuser
);

    localparam int unsigned NUM_STAGES = dv16_pkg::DVD_W / BITS_PER_STAGE;

    logic                     en;
    logic                     in_op;
    logic [dv16_pkg::DVD_W-1:0]  in_dvd;
    logic [dv16_pkg::DVS_W-1:0]  in_dvs;
    logic [dv16_pkg::FLAG_W-1:0] in_flags;
    dv16_pkg::t_div_word      n_pre;

    logic                     r_pre_valid;
    dv16_pkg::t_div_word      r_pre;

    logic                     stg_valid [NUM_STAGES+1];
    dv16_pkg::t_div_word      stg_word  [NUM_STAGES+1];

    dv16_pkg::t_div_word      last;
    logic                     ovf;
    logic [dv16_pkg::DVS_W-1:0]  q16;
    logic [dv16_pkg::DVS_W-1:0]  r16;
    logic [dv16_pkg::DVD_W-1:0]  n_result;
    logic                     n_wb;
    logic [dv16_pkg::FLAG_W-1:0] n_flags;

    logic                     r_out_valid;
    logic [dv16_pkg::DVD_W-1:0]  r_out_result;
    logic                     r_out_wb;
    logic [dv16_pkg::FLAG_W-1:0] r_out_flags;
    logic                     r_out_zd;

    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en;

    assign in_op    = i_s_tuser;
    assign in_dvd   = i_s_tdata[31:0];
    assign in_dvs   = i_s_tdata[47:32];
    assign in_flags = i_s_tdata[51:48];

    // Operand conditioning: take magnitudes for a signed divide.
    always_comb begin
        n_pre          = '0;
        n_pre.op       = in_op;
        n_pre.neg_dvd  = (in_op == dv16_pkg::OP_DIVS) && in_dvd[dv16_pkg::DVD_W-1];
        n_pre.neg_quo  = (in_op == dv16_pkg::OP_DIVS) &&
                         (in_dvd[dv16_pkg::DVD_W-1] != in_dvs[dv16_pkg::DVS_W-1]);
        n_pre.div_zero = (in_dvs == '0);
        n_pre.flags    = in_flags;
        n_pre.dvd      = in_dvd;
        n_pre.quo      = n_pre.neg_dvd ? (~in_dvd + 32'd1) : in_dvd;
        n_pre.rem      = '0;
        if ((in_op == dv16_pkg::OP_DIVS) && in_dvs[dv16_pkg::DVS_W-1]) begin
            n_pre.dvs_mag = ~in_dvs + 16'd1;
        end else begin
            n_pre.dvs_mag = in_dvs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid <= 1'b0;
        end else if (en) begin
            r_pre_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pre <= n_pre;
        end
    end

    assign stg_valid[0] = r_pre_valid;
    assign stg_word[0]  = r_pre;

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        dv16_step_stage #(
            .BITS_PER_STAGE(BITS_PER_STAGE)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (stg_valid[g]),
            .i_word  (stg_word[g]),
            .o_valid (stg_valid[g+1]),
            .o_word  (stg_word[g+1])
        );
    end

    // Range check, sign restore and flag update.
    assign last = stg_word[NUM_STAGES];

    always_comb begin
        if (last.op == dv16_pkg::OP_DIVU) begin
            ovf = (last.quo[dv16_pkg::DVD_W-1:dv16_pkg::DVS_W] != '0);
        end else if (last.neg_quo) begin
            ovf = (last.quo > dv16_pkg::QUO_NEG_MAX);
        end else begin
            ovf = (last.quo > dv16_pkg::QUO_POS_MAX);
        end

        q16 = last.neg_quo ? (~last.quo[dv16_pkg::DVS_W-1:0] + 16'd1)
                           : last.quo[dv16_pkg::DVS_W-1:0];
        r16 = last.neg_dvd ? (~last.rem + 16'd1) : last.rem;

        n_result = last.dvd;
        n_wb     = 1'b0;
        n_flags  = last.flags;
        if (last.div_zero) begin
            n_flags[dv16_pkg::FLAG_V] = 1'b0;
        end else if (ovf) begin
            n_flags[dv16_pkg::FLAG_V] = 1'b1;
        end else begin
            n_flags                   = '0;
            n_flags[dv16_pkg::FLAG_N] = q16[dv16_pkg::DVS_W-1];
            n_flags[dv16_pkg::FLAG_Z] = (q16 == '0);
            n_result                  = {r16, q16};
            n_wb                      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= stg_valid[NUM_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_result <= n_result;
            r_out_wb     <= n_wb;
            r_out_flags  <= n_flags;
            r_out_zd     <= last.div_zero;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_flags, r_out_result};
    assign o_m_tuser  = {r_out_zd, r_out_wb};

endmodule
